/* src/length_prefixed_frame_deframer_defines.svh */
// Assertion macros used by the frame deframer assertion checker.
`ifndef LENGTH_PREFIXED_FRAME_DEFRAMER_DEFINES_SVH
`define LENGTH_PREFIXED_FRAME_DEFRAMER_DEFINES_SVH

// Clocked assertion that is switched off while reset is asserted.
`define LPFD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define LPFD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* src/lpfd_pkg.sv */
// Types and constants for the length-prefixed frame deframer.
package lpfd_pkg;

  // Largest payload that a frame may announce.
  localparam int unsigned MaxPayload = 1024;
  // Width of the byte counter and of the reported frame length.
  localparam int unsigned CountW = 11;

  // Header byte positions within a frame.
  localparam logic [CountW-1:0] PosVersion = CountW'(0);
  localparam logic [CountW-1:0] PosType    = CountW'(1);
  localparam logic [CountW-1:0] PosLenLo   = CountW'(2);
  localparam logic [CountW-1:0] PosLenHi   = CountW'(3);
  localparam logic [CountW-1:0] HeaderBytes = CountW'(4);

  // The only header version that is accepted.
  localparam logic [7:0] FrameVersion = 8'd1;

  typedef enum logic {
    CMD_FEED  = 1'b0,
    CMD_CLEAR = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_BUSY        = 2'd0,
    ST_DONE        = 2'd1,
    ST_BAD_VERSION = 2'd2,
    ST_TOO_LARGE   = 2'd3
  } status_e;

  typedef struct packed {
    cmd_e       command;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    status_e           status;
    logic [7:0]        frame_type;
    logic              payload_valid;
    logic [7:0]        payload_byte;
    logic [CountW-1:0] frame_length;
  } out_t;

endpackage

/* src/length_prefixed_frame_deframer.sv */
// Length-prefixed frame deframer: parses a byte stream into header and payload.
//
// One byte transaction is accepted per clock cycle while in_ready_o is high, and
// each one yields exactly one result transaction in the next cycle from the output
// register. The header (version, type, 16-bit little-endian length) is checked on
// its fourth byte; payload bytes pass through tagged with the frame type, and the
// last byte of a frame reports frame done with the length. in_ready_o is high
// whenever the output register is empty or its result is taken in the same cycle,
// so the rate is set by that single output register and the consumer's ready.
module length_prefixed_frame_deframer (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  lpfd_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output lpfd_pkg::out_t  out_data_o
);

  // Parser state.
  logic [lpfd_pkg::CountW-1:0] count_q, count_d;
  logic                        version_ok_q, version_ok_d;
  logic [7:0]                  type_q, type_d;
  logic [lpfd_pkg::CountW-1:0] len_q, len_d;

  // Output register.
  logic           out_valid_q, out_valid_d;
  lpfd_pkg::out_t out_data_q, out_data_d;

  logic                        accept;
  logic [15:0]                 len_full;
  logic [lpfd_pkg::CountW-1:0] count_inc;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign len_full   = {in_data_i.data_byte, len_q[7:0]};
  assign count_inc  = count_q + lpfd_pkg::CountW'(1);

  // Next parser state and result for the incoming byte.
  always_comb begin
    count_d      = count_q;
    version_ok_d = version_ok_q;
    type_d       = type_q;
    len_d        = len_q;
    out_data_d   = '0;
    out_data_d.status = lpfd_pkg::ST_BUSY;

    if (in_data_i.command == lpfd_pkg::CMD_CLEAR) begin
      count_d      = '0;
      version_ok_d = 1'b0;
      type_d       = '0;
      len_d        = '0;
    end else begin
      case (count_q)
        lpfd_pkg::PosVersion: begin
          version_ok_d = (in_data_i.data_byte == lpfd_pkg::FrameVersion);
          count_d      = count_inc;
        end
        lpfd_pkg::PosType: begin
          type_d  = in_data_i.data_byte;
          count_d = count_inc;
        end
        lpfd_pkg::PosLenLo: begin
          len_d   = {{(lpfd_pkg::CountW-8){1'b0}}, in_data_i.data_byte};
          count_d = count_inc;
        end
        lpfd_pkg::PosLenHi: begin
          out_data_d.frame_type = type_q;
          // Version is checked before the length; errors and empty frames clear.
          if (!version_ok_q || len_full > 16'(lpfd_pkg::MaxPayload) ||
              len_full == 16'd0) begin
            if (!version_ok_q) begin
              out_data_d.status = lpfd_pkg::ST_BAD_VERSION;
            end else if (len_full == 16'd0) begin
              out_data_d.status = lpfd_pkg::ST_DONE;
            end else begin
              out_data_d.status = lpfd_pkg::ST_TOO_LARGE;
            end
            count_d      = '0;
            version_ok_d = 1'b0;
            type_d       = '0;
            len_d        = '0;
          end else begin
            len_d   = len_full[lpfd_pkg::CountW-1:0];
            count_d = lpfd_pkg::HeaderBytes;
          end
        end
        default: begin
          // Payload byte passes through; the last one closes the frame.
          out_data_d.frame_type    = type_q;
          out_data_d.payload_valid = 1'b1;
          out_data_d.payload_byte  = in_data_i.data_byte;
          count_d                  = count_inc;
          if ((count_inc - lpfd_pkg::HeaderBytes) >= len_q) begin
            out_data_d.status       = lpfd_pkg::ST_DONE;
            out_data_d.frame_length = len_q;
            count_d                 = '0;
            version_ok_d            = 1'b0;
            type_d                  = '0;
            len_d                   = '0;
          end
        end
      endcase
    end
  end

  // Output valid follows accepted transactions and drains on ready.
  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control and parser state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      version_ok_q <= 1'b0;
      type_q       <= '0;
      len_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        count_q      <= count_d;
        version_ok_q <= version_ok_d;
        type_q       <= type_d;
        len_q        <= len_d;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

/* src/lpfd_checker.sv */
// Port-level assertion checker for the frame deframer, with its bind.
`include "length_prefixed_frame_deframer_defines.svh"

module lpfd_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input lpfd_pkg::in_t  in_data_i,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input lpfd_pkg::out_t out_data_o
);

  // A stalled result transaction holds its value.
  `LPFD_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o), "result changed while stalled")

  // A clear command yields an all-zero in-progress result on the next cycle.
  `LPFD_ASSERT(a_clear_result, in_valid_i && in_ready_o && in_data_i.command == lpfd_pkg::CMD_CLEAR |=> out_valid_o && out_data_o == '0, "clear did not give an empty result")

  // A frame length is only reported together with frame done.
  `LPFD_ASSERT(a_len_with_done, out_valid_o && out_data_o.frame_length != '0 |-> out_data_o.status == lpfd_pkg::ST_DONE, "frame length without frame done")

  // Header errors never carry a payload byte.
  `LPFD_ASSERT(a_no_payload_on_error, out_valid_o && out_data_o.payload_valid |-> out_data_o.status == lpfd_pkg::ST_BUSY || out_data_o.status == lpfd_pkg::ST_DONE, "payload byte on a header error")

  // No result is shown while reset holds.
  `LPFD_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> !out_valid_o, "result valid during reset")

endmodule

bind length_prefixed_frame_deframer lpfd_checker u_lpfd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

/* verif/testbench.sv */
// Self-checking testbench for the length-prefixed frame deframer.
module testbench;

  localparam int unsigned RandomBytes = 1850;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned SettleCycles = 8;

  // One queued stream byte, optionally held back until the block has drained.
  typedef struct {
    lpfd_pkg::in_t item;
    bit            drain_first;
  } stim_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  lpfd_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  lpfd_pkg::out_t out_data;

  stim_t          stream_q[$];
  lpfd_pkg::out_t deframed_q[$];
  bit    drain_next = 1'b0;
  int    error_count = 0;
  int unsigned cycle_count = 0;

  // Parser state of the prediction.
  logic [lpfd_pkg::CountW-1:0] frame_pos = '0;
  logic [7:0]                  seen_version = '0;
  logic [7:0]                  seen_type = '0;
  logic [15:0]                 seen_length = '0;

  // Sender burst shaping and drain tracking.
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  int unsigned in_flight = 0;

  // Receiver stall pattern.
  int unsigned ready_cycles = 0;
  int unsigned hold_left = 0;
  int unsigned ready_mode = 0;

  length_prefixed_frame_deframer u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Drop any partial frame from the predicted parser state.
  function automatic void clear_frame_state();
    frame_pos = '0;
    seen_version = '0;
    seen_type = '0;
    seen_length = '0;
  endfunction

  // Predict the result for one stream byte and advance the parser state.
  function automatic lpfd_pkg::out_t deframe_byte(input lpfd_pkg::in_t item);
    lpfd_pkg::out_t res;
    res = '0;
    res.status = lpfd_pkg::ST_BUSY;
    if (item.command == lpfd_pkg::CMD_CLEAR) begin
      clear_frame_state();
    end else begin
      case (frame_pos)
        lpfd_pkg::PosVersion: begin
          seen_version = item.data_byte;
          frame_pos = lpfd_pkg::PosType;
        end
        lpfd_pkg::PosType: begin
          seen_type = item.data_byte;
          frame_pos = lpfd_pkg::PosLenLo;
        end
        lpfd_pkg::PosLenLo: begin
          seen_length = {8'h00, item.data_byte};
          frame_pos = lpfd_pkg::PosLenHi;
        end
        lpfd_pkg::PosLenHi: begin
          seen_length = {item.data_byte, seen_length[7:0]};
          res.frame_type = seen_type;
          // The version is checked ahead of the length.
          if (seen_version != lpfd_pkg::FrameVersion) begin
            res.status = lpfd_pkg::ST_BAD_VERSION;
            clear_frame_state();
          end else if (seen_length > 16'(lpfd_pkg::MaxPayload)) begin
            res.status = lpfd_pkg::ST_TOO_LARGE;
            clear_frame_state();
          end else if (seen_length == 16'd0) begin
            res.status = lpfd_pkg::ST_DONE;
            clear_frame_state();
          end else begin
            frame_pos = lpfd_pkg::HeaderBytes;
          end
        end
        default: begin
          // Payload byte passes through with the frame type.
          res.frame_type = seen_type;
          res.payload_valid = 1'b1;
          res.payload_byte = item.data_byte;
          frame_pos = frame_pos + lpfd_pkg::CountW'(1);
          if (16'(frame_pos - lpfd_pkg::HeaderBytes) >= seen_length) begin
            res.status = lpfd_pkg::ST_DONE;
            res.frame_length = seen_length[lpfd_pkg::CountW-1:0];
            clear_frame_state();
          end
        end
      endcase
    end
    return res;
  endfunction

  task automatic queue_byte(input lpfd_pkg::cmd_e cmd, input logic [7:0] value);
    stim_t s;
    s.item.command = cmd;
    s.item.data_byte = value;
    s.drain_first = drain_next;
    drain_next = 1'b0;
    stream_q.push_back(s);
  endtask

  // Header followed by a number of random payload bytes.
  task automatic queue_frame(input logic [7:0] version, input logic [7:0] ftype,
                             input logic [15:0] length, input int unsigned payload_bytes);
    queue_byte(lpfd_pkg::CMD_FEED, version);
    queue_byte(lpfd_pkg::CMD_FEED, ftype);
    queue_byte(lpfd_pkg::CMD_FEED, length[7:0]);
    queue_byte(lpfd_pkg::CMD_FEED, length[15:8]);
    for (int unsigned i = 0; i < payload_bytes; i++) begin
      queue_byte(lpfd_pkg::CMD_FEED, 8'($urandom_range(0, 255)));
    end
  endtask

  // Driver: offers queued bytes in bursts and predicts each accepted transaction.
  always @(posedge clk or negedge rst_n) begin
    logic busy;
    logic offer;
    stim_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      busy = in_valid;
      offer = 1'b0;
      if (in_valid && in_ready) begin
        deframed_q.push_back(deframe_byte(in_data));
        in_flight++;
        busy = 1'b0;
      end
      if (out_valid && out_ready) begin
        in_flight--;
      end
      if (!busy) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (stream_q.size() > 0 && (!stream_q[0].drain_first || in_flight == 0)) begin
          nxt = stream_q.pop_front();
          offer = 1'b1;
          in_data <= nxt.item;
          burst_left--;
          if (burst_left == 0) begin
            gap_left = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 20)
                                                  : $urandom_range(1, 4);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                    : $urandom_range(1, 24);
          end
        end
        in_valid <= offer;
      end
    end
  end

  // Receiver: random stall patterns and random hold-offs, with one forced long hold-off.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      ready_cycles++;
      if (ready_cycles == 600) begin
        hold_left = 250;
      end else if (ready_cycles % 256 == 0) begin
        ready_mode = $urandom_range(0, 4);
        if (ready_mode == 4) begin
          hold_left = $urandom_range(60, 200);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (ready_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 3) != 0);
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  // Monitor: compare each result transaction with the oldest prediction.
  always @(posedge clk) begin
    lpfd_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (deframed_q.size() == 0) begin
        $error("result transaction with nothing predicted: %h", out_data);
        error_count++;
      end else begin
        want = deframed_q.pop_front();
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          error_count++;
        end
        if (out_data.frame_type !== want.frame_type) begin
          $error("frame_type: expected %h, got %h", want.frame_type, out_data.frame_type);
          error_count++;
        end
        if (out_data.payload_valid !== want.payload_valid) begin
          $error("payload_valid: expected %b, got %b", want.payload_valid,
                 out_data.payload_valid);
          error_count++;
        end
        if (out_data.payload_byte !== want.payload_byte) begin
          $error("payload_byte: expected %h, got %h", want.payload_byte, out_data.payload_byte);
          error_count++;
        end
        if (out_data.frame_length !== want.frame_length) begin
          $error("frame_length: expected %0d, got %0d", want.frame_length,
                 out_data.frame_length);
          error_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("length_prefixed_frame_deframer test failed");
      $finish;
    end
  end

  initial begin
    int unsigned random_start;
    int unsigned next_drain;
    int unsigned kind;
    int unsigned len;
    int unsigned noise_len;
    logic [7:0] version;

    // Directed part: extremes of the header checks and the clear command.
    queue_byte(lpfd_pkg::CMD_CLEAR, 8'hFF);
    queue_frame(8'h01, 8'hFF, 16'd0, 0);
    queue_frame(8'h01, 8'h00, 16'd1, 0);
    queue_byte(lpfd_pkg::CMD_FEED, 8'hFF);
    queue_frame(8'h00, 8'h7E, 16'd5, 0);
    queue_frame(8'h01, 8'h33, 16'd1025, 0);
    queue_frame(8'hFF, 8'h11, 16'hFFFF, 0);
    queue_frame(8'h01, 8'h22, 16'd3, 0);
    queue_byte(lpfd_pkg::CMD_FEED, 8'h00);
    queue_byte(lpfd_pkg::CMD_CLEAR, 8'h00);

    // Random part opens with one largest frame after a full drain.
    random_start = stream_q.size();
    drain_next = 1'b1;
    queue_frame(8'h01, 8'($urandom_range(0, 255)), 16'(lpfd_pkg::MaxPayload),
                lpfd_pkg::MaxPayload);
    next_drain = 400;
    while (stream_q.size() - random_start < RandomBytes) begin
      if (stream_q.size() - random_start >= next_drain) begin
        drain_next = 1'b1;
        next_drain += 400;
      end
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        // Well-formed frame, mostly short, sometimes cut off by a clear.
        case ($urandom_range(0, 9))
          0: len = $urandom_range(65, 300);
          1, 2, 3: len = $urandom_range(9, 64);
          default: len = $urandom_range(0, 8);
        endcase
        if (len > 0 && $urandom_range(0, 9) == 0) begin
          queue_frame(8'h01, 8'($urandom_range(0, 255)), 16'(len),
                      $urandom_range(0, len - 1));
          queue_byte(lpfd_pkg::CMD_CLEAR, 8'($urandom_range(0, 255)));
        end else begin
          queue_frame(8'h01, 8'($urandom_range(0, 255)), 16'(len), len);
        end
      end else if (kind < 78) begin
        len = ($urandom_range(0, 3) == 0) ? lpfd_pkg::MaxPayload + 1
                                          : $urandom_range(lpfd_pkg::MaxPayload + 1, 65535);
        queue_frame(8'h01, 8'($urandom_range(0, 255)), 16'(len), 0);
      end else if (kind < 85) begin
        version = 8'($urandom_range(0, 255));
        if (version == lpfd_pkg::FrameVersion) begin
          version = 8'h00;
        end
        queue_frame(version, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)), 0);
      end else if (kind < 92) begin
        // Noise bytes, usually followed by a clear to realign.
        noise_len = $urandom_range(1, 6);
        for (int unsigned i = 0; i < noise_len; i++) begin
          queue_byte(($urandom_range(0, 9) == 0) ? lpfd_pkg::CMD_CLEAR : lpfd_pkg::CMD_FEED,
                     8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 4) != 0) begin
          queue_byte(lpfd_pkg::CMD_CLEAR, 8'($urandom_range(0, 255)));
        end
      end else begin
        queue_byte(lpfd_pkg::CMD_CLEAR, 8'($urandom_range(0, 255)));
      end
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for the stream to be taken and every result to come back.
    while (stream_q.size() != 0 || in_valid) @(posedge clk);
    while (deframed_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);

    if (error_count == 0) begin
      $display("length_prefixed_frame_deframer test passed");
    end else begin
      $display("length_prefixed_frame_deframer test failed");
    end
    $finish;
  end

endmodule
